@@ sv/dial_string_to_packed_bcd_macros.svh @@
// Assertion helpers used by the packing module.
`ifndef DIAL_STRING_TO_PACKED_BCD_MACROS_SVH
`define DIAL_STRING_TO_PACKED_BCD_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DSBCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DSBCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dsbcd_pkg.sv @@
package dsbcd_pkg;

    localparam int MAX_DIGITS_DEF = 255;

    // ASCII codes recognized in a dial string
    localparam logic [7:0] CHR_0    = 8'h30;
    localparam logic [7:0] CHR_9    = 8'h39;
    localparam logic [7:0] CHR_STAR = 8'h2A;
    localparam logic [7:0] CHR_HASH = 8'h23;
    localparam logic [7:0] CHR_PLUS = 8'h2B;
    localparam logic [7:0] CHR_LA   = 8'h61;
    localparam logic [7:0] CHR_LC   = 8'h63;
    localparam logic [7:0] CHR_UA   = 8'h41;
    localparam logic [7:0] CHR_UC   = 8'h43;

    // BCD digit codes
    localparam logic [3:0] DIG_STAR = 4'hA;
    localparam logic [3:0] DIG_HASH = 4'hB;
    localparam logic [3:0] DIG_C    = 4'hC;
    localparam logic [3:0] NIB_PAD  = 4'hF;

    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_PLUS,
        KIND_BAD
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
    } map_t;

    typedef struct packed {
        logic [7:0] byte_count;
        status_t    status;
        logic       final_res;
        logic       has_byte;
        logic [7:0] packed_byte;
    } res_t;

endpackage

@@ sv/dsbcd_map.sv @@
module dsbcd_map
    import dsbcd_pkg::*;
(
    input  logic [7:0] char_code,
    output map_t       map
);

    always_comb
    begin
        map.kind  = KIND_DIGIT;
        map.digit = '0;
        unique case (char_code) inside
            [CHR_0:CHR_9]:
            begin
                map.digit = 4'(char_code - CHR_0);
            end
            CHR_STAR:
            begin
                map.digit = DIG_STAR;
            end
            CHR_HASH:
            begin
                map.digit = DIG_HASH;
            end
            [CHR_LA:CHR_LC]:
            begin
                map.digit = 4'(char_code - CHR_LA) + DIG_C;
            end
            [CHR_UA:CHR_UC]:
            begin
                map.digit = 4'(char_code - CHR_UA) + DIG_C;
            end
            CHR_PLUS:
            begin
                map.kind = KIND_PLUS;
            end
            default:
            begin
                map.kind = KIND_BAD;
            end
        endcase
    end

endmodule

@@ sv/dsbcd_pack.sv @@
`include "dial_string_to_packed_bcd_macros.svh"

module dsbcd_pack
    import dsbcd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  map_t map,
    input  logic is_last,
    output logic res_valid,
    output res_t res
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

    logic [3:0]       held_reg, held_next;
    logic             pending_reg, pending_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic             error_reg, error_next;

    logic [CNT_W-1:0] total_inc;
    logic [CNT_W:0]   half_cur, half_inc;
    logic [7:0]       count_cur, count_inc;

    assign total_inc = total_reg + 1'b1;
    assign half_cur  = ({1'b0, total_reg} + 1'b1) >> 1;
    assign half_inc  = ({1'b0, total_inc} + 1'b1) >> 1;
    assign count_cur = 8'(half_cur);
    assign count_inc = 8'(half_inc);

    always_comb
    begin
        held_next    = held_reg;
        pending_next = pending_reg;
        total_next   = total_reg;
        error_next   = error_reg;
        res_valid    = 1'b0;
        res          = '0;
        res.status   = ST_OK;

        if (step)
        begin
            if (error_reg)
            begin
                // swallow the rest of a failed string
                if (is_last)
                begin
                    held_next    = '0;
                    pending_next = 1'b0;
                    total_next   = '0;
                    error_next   = 1'b0;
                end
            end
            else if (map.kind == KIND_BAD || (map.kind == KIND_DIGIT && total_reg >= CNT_MAX))
            begin
                res_valid     = 1'b1;
                res.final_res = 1'b1;
                res.status    = (map.kind == KIND_BAD) ? ST_INVALID : ST_OVERFLOW;
                held_next     = '0;
                pending_next  = 1'b0;
                if (is_last)
                begin
                    total_next = '0;
                    error_next = 1'b0;
                end
                else
                begin
                    error_next = 1'b1;
                end
            end
            else if (map.kind == KIND_PLUS)
            begin
                if (is_last)
                begin
                    res_valid       = 1'b1;
                    res.final_res   = 1'b1;
                    res.has_byte    = pending_reg;
                    res.packed_byte = pending_reg ? {NIB_PAD, held_reg} : 8'h00;
                    res.byte_count  = count_cur;
                    held_next       = '0;
                    pending_next    = 1'b0;
                    total_next      = '0;
                end
            end
            else if (pending_reg)
            begin
                // second digit of a pair goes to the high nibble
                res_valid       = 1'b1;
                res.has_byte    = 1'b1;
                res.packed_byte = {map.digit, held_reg};
                res.final_res   = is_last;
                res.byte_count  = is_last ? count_inc : 8'h00;
                held_next       = '0;
                pending_next    = 1'b0;
                total_next      = is_last ? '0 : total_inc;
            end
            else if (is_last)
            begin
                res_valid       = 1'b1;
                res.has_byte    = 1'b1;
                res.final_res   = 1'b1;
                res.packed_byte = {NIB_PAD, map.digit};
                res.byte_count  = count_inc;
                total_next      = '0;
            end
            else
            begin
                held_next    = map.digit;
                pending_next = 1'b1;
                total_next   = total_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            pending_reg <= 1'b0;
            total_reg   <= '0;
            error_reg   <= 1'b0;
        end
        else
        begin
            held_reg    <= held_next;
            pending_reg <= pending_next;
            total_reg   <= total_next;
            error_reg   <= error_next;
        end
    end

    `DSBCD_ASSERT_NOW(a_pending_odd, clk, rst_n, pending_reg, total_reg[0],
        "held digit with an even digit total")
    `DSBCD_ASSERT_NOW(a_error_no_held, clk, rst_n, error_reg, !pending_reg,
        "digit held after the string failed")
    `DSBCD_ASSERT_NOW(a_err_res_shape, clk, rst_n,
        res_valid && res.status != ST_OK,
        res.final_res && !res.has_byte && res.byte_count == 8'h00,
        "error result not a bare final result")
    `DSBCD_ASSERT_NEXT(a_final_clears, clk, rst_n,
        step && res_valid && res.final_res && res.status == ST_OK,
        !pending_reg && total_reg == '0 && !error_reg,
        "state not cleared after a good final result")

endmodule

@@ sv/dial_string_to_packed_bcd.sv @@
// Dial string to packed telephony BCD encoder. Feed one ASCII character per request
// on the slave side with tlast on the final character; '0'-'9', '*', '#', a-c and
// A-C become BCD digits 0-E, '+' is skipped, anything else ends the string with an
// invalid-character status and the rest up to tlast is dropped. Digits leave packed
// two to a byte, first digit in the low nibble, one request per completed byte; the
// string's last request carries tlast, an odd tail padded with F in the high nibble,
// and the total byte count. More than MAX_DIGITS digits ends the string with an
// overflow status. One character is taken every cycle: a character register feeds
// a single pass of decode and pairing logic that writes the result register, and
// only the result register's backpressure slows the input.
module dial_string_to_packed_bcd
    import dsbcd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] packed_byte, [15:8] byte_count
    output logic [2:0]  m_tuser,   // [0] has_byte, [2:1] status
    output logic        m_tlast    // final_res
);

    // character register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // result register
    logic       out_valid_reg;
    res_t       out_res_reg;

    logic advance;
    logic step;
    map_t map;
    logic res_valid;
    res_t res;

    // result register frees up when empty or being drained this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    dsbcd_map u_map
    (
        .char_code (in_char_reg),
        .map       (map)
    );

    dsbcd_pack #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_pack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .map       (map),
        .is_last   (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.byte_count, out_res_reg.packed_byte};
    assign m_tuser  = {out_res_reg.status, out_res_reg.has_byte};
    assign m_tlast  = out_res_reg.final_res;

endmodule

@@ bench/dial_string_to_packed_bcd_tb.sv @@
`timescale 1ns / 1ps

// Bench for the dial string encoder: ASCII characters go in on the slave side,
// packed BCD bytes and end-of-string reports come back on the master side and are
// checked against a local model of the encoder.
module dial_string_to_packed_bcd_tb;
    import dsbcd_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int DIGIT_LIMIT    = MAX_DIGITS_DEF;
    localparam int ITEM_TARGET    = 1700;
    localparam int IDLE_PCT       = 6;
    localparam int QUIET_FROM     = 800;
    localparam int QUIET_TO       = 1400;
    localparam int HOLD_AFTER     = 60;    // results seen before the long sink stall
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } dial_char_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] char_code
    logic        s_tlast;    // is_last
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [7:0] packed_byte, [15:8] byte_count
    logic [2:0]  m_tuser;    // [0] has_byte, [2:1] status
    logic        m_tlast;    // final_res

    dial_char_t char_q[$];   // characters waiting to be sent
    res_t       bcd_q[$];    // encoder output still owed by the DUT

    // Model state of the encoder
    logic [3:0] held_nib;
    logic       nib_pending;
    int         digits_seen;
    logic       string_dead;

    int  cyc;
    int  quiet_idle;
    int  chars_sent;
    int  strings_sent;
    int  results_seen;
    int  bytes_seen;
    int  invalid_seen;
    int  overflow_seen;
    int  errors;
    int  stall_cnt;
    int  hold_left;
    bit  hold_done;

    dial_string_to_packed_bcd #(
        .MAX_DIGITS (DIGIT_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------

    // Sort a character into digit / skip / bad, with its BCD nibble.
    function automatic map_t classify_char(input logic [7:0] ch);
        map_t m;
        m.kind  = KIND_BAD;
        m.digit = 4'h0;
        if (ch >= CHR_0 && ch <= CHR_9) begin
            m.kind  = KIND_DIGIT;
            m.digit = 4'(ch - CHR_0);
        end else if (ch == CHR_STAR) begin
            m.kind  = KIND_DIGIT;
            m.digit = DIG_STAR;
        end else if (ch == CHR_HASH) begin
            m.kind  = KIND_DIGIT;
            m.digit = DIG_HASH;
        end else if (ch >= CHR_LA && ch <= CHR_LC) begin
            m.kind  = KIND_DIGIT;
            m.digit = DIG_C + 4'(ch - CHR_LA);
        end else if (ch >= CHR_UA && ch <= CHR_UC) begin
            m.kind  = KIND_DIGIT;
            m.digit = DIG_C + 4'(ch - CHR_UA);
        end else if (ch == CHR_PLUS) begin
            m.kind  = KIND_PLUS;
        end
        return m;
    endfunction

    function automatic void restart_string();
        held_nib    = 4'h0;
        nib_pending = 1'b0;
        digits_seen = 0;
        string_dead = 1'b0;
    endfunction

    // Error: the string is over; the rest up to tlast is swallowed.
    function automatic void kill_string(input logic last);
        if (last)
            restart_string();
        else begin
            string_dead = 1'b1;
            nib_pending = 1'b0;
            held_nib    = 4'h0;
        end
    endfunction

    // Advance the model by one character; returns 1 when a result is due.
    function automatic bit encode_char(input logic [7:0] ch, input logic last,
                                       output res_t r);
        map_t m;
        r = '0;
        if (string_dead) begin
            if (last)
                restart_string();
            return 1'b0;
        end
        m = classify_char(ch);
        if (m.kind == KIND_BAD) begin
            r.final_res = 1'b1;
            r.status    = ST_INVALID;
            kill_string(last);
            return 1'b1;
        end
        if (m.kind == KIND_PLUS) begin
            if (!last)
                return 1'b0;
            // '+' closes the string: flush an odd tail with the pad nibble
            r.final_res  = 1'b1;
            r.status     = ST_OK;
            r.byte_count = 8'((digits_seen + 1) / 2);
            if (nib_pending) begin
                r.has_byte    = 1'b1;
                r.packed_byte = {NIB_PAD, held_nib};
            end
            restart_string();
            return 1'b1;
        end
        if (digits_seen >= DIGIT_LIMIT) begin
            r.final_res = 1'b1;
            r.status    = ST_OVERFLOW;
            kill_string(last);
            return 1'b1;
        end
        digits_seen++;
        if (nib_pending) begin
            r.has_byte    = 1'b1;
            r.packed_byte = {m.digit, held_nib};
            r.status      = ST_OK;
            nib_pending   = 1'b0;
            held_nib      = 4'h0;
            if (last) begin
                r.final_res  = 1'b1;
                r.byte_count = 8'((digits_seen + 1) / 2);
                restart_string();
            end
            return 1'b1;
        end
        if (last) begin
            r.has_byte    = 1'b1;
            r.packed_byte = {NIB_PAD, m.digit};
            r.final_res   = 1'b1;
            r.status      = ST_OK;
            r.byte_count  = 8'((digits_seen + 1) / 2);
            restart_string();
            return 1'b1;
        end
        held_nib    = m.digit;
        nib_pending = 1'b1;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_char(input logic [7:0] code, input logic last);
        dial_char_t c;
        c.code = code;
        c.last = last;
        char_q.push_back(c);
    endfunction

    // Random legal dial character; '+' only when allowed.
    function automatic logic [7:0] pick_dial_char(input bit allow_plus);
        int n;
        n = $urandom_range(0, allow_plus ? 15 : 14);
        if (n <= 9)
            return CHR_0 + 8'(n);
        else if (n == 10)
            return CHR_STAR;
        else if (n == 11)
            return CHR_HASH;
        else if (n <= 14)
            return ($urandom_range(0, 1) ? CHR_LA : CHR_UA) + 8'(n - 12);
        return CHR_PLUS;
    endfunction

    function automatic logic [7:0] pick_bad_char();
        logic [7:0] ch;
        map_t       m;
        do
        begin
            ch = 8'($urandom_range(0, 255));
            m  = classify_char(ch);
        end
        while (m.kind != KIND_BAD);
        return ch;
    endfunction

    // One string of len characters, tlast on the final one.
    // shape: 0 well formed, 1 one bad character inside, 2 raw byte noise,
    // 3 digits only (for the long strings).
    function automatic void queue_string(input int len, input int shape);
        int         bad_at;
        logic [7:0] ch;
        bad_at = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
            case (shape)
                0:       ch = pick_dial_char($urandom_range(0, 9) == 0);
                1:       ch = (i == bad_at) ? pick_bad_char()
                                            : pick_dial_char($urandom_range(0, 9) == 0);
                2:       ch = 8'($urandom_range(0, 255));
                default: ch = pick_dial_char(1'b0);
            endcase
            queue_char(ch, i == len - 1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Cycle counter and quiet window (no idling on either side)
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cyc <= 0;
        else
            cyc <= cyc + 1;
    end

    assign quiet_idle = (cyc >= QUIET_FROM && cyc < QUIET_TO);

    // ------------------------------------------------------------------
    // Character driver: runs the model on every accepted request
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_chars
        res_t       exp_res;
        dial_char_t nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                chars_sent <= chars_sent + 1;
                if (s_tlast)
                    strings_sent <= strings_sent + 1;
                if (encode_char(s_tdata, s_tlast, exp_res))
                    bcd_q.push_back(exp_res);
            end
            // slot is free: offer the next character or idle
            if (!s_tvalid || s_tready) begin
                if (char_q.size() != 0 &&
                    (quiet_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = char_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.code;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink ready: random stalls plus one long hold-off so the DUT backs up
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= quiet_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_bcd
        res_t got;
        res_t exp_res;
        if (rst_n && m_tvalid && m_tready) begin
            got.packed_byte = m_tdata[7:0];
            got.byte_count  = m_tdata[15:8];
            got.has_byte    = m_tuser[0];
            got.status      = status_t'(m_tuser[2:1]);
            got.final_res   = m_tlast;
            results_seen <= results_seen + 1;
            if (got.has_byte)
                bytes_seen <= bytes_seen + 1;
            if (got.status == ST_INVALID)
                invalid_seen <= invalid_seen + 1;
            if (got.status == ST_OVERFLOW)
                overflow_seen <= overflow_seen + 1;
            if (bcd_q.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("[%0t] unexpected result: byte=%02h has=%0b fin=%0b st=%0d cnt=%0d",
                             $realtime, got.packed_byte, got.has_byte, got.final_res,
                             got.status, got.byte_count);
                errors <= errors + 1;
            end else begin
                exp_res = bcd_q.pop_front();
                if (got.packed_byte !== exp_res.packed_byte ||
                    got.has_byte    !== exp_res.has_byte    ||
                    got.final_res   !== exp_res.final_res   ||
                    got.status      !== exp_res.status      ||
                    got.byte_count  !== exp_res.byte_count) begin
                    if (errors < MAX_REPORTS) begin
                        $display("[%0t] mismatch exp: byte=%02h has=%0b fin=%0b st=%0d cnt=%0d",
                                 $realtime, exp_res.packed_byte, exp_res.has_byte,
                                 exp_res.final_res, exp_res.status, exp_res.byte_count);
                        $display("[%0t]          got: byte=%02h has=%0b fin=%0b st=%0d cnt=%0d",
                                 $realtime, got.packed_byte, got.has_byte, got.final_res,
                                 got.status, got.byte_count);
                    end
                    errors <= errors + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any request moving on either side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                     stall_cnt, bcd_q.size());
            $display("*** FAILED ***");
            $finish;
        end else
            stall_cnt <= stall_cnt + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial begin
        chars_sent    = 0;
        strings_sent  = 0;
        results_seen  = 0;
        bytes_seen    = 0;
        invalid_seen  = 0;
        overflow_seen = 0;
        errors        = 0;
        stall_cnt     = 0;
        restart_string();

        // single digit: odd tail padded with F
        queue_char(CHR_0, 1'b1);
        // every digit class, a skipped plus mid-string, odd tail
        queue_char(CHR_0, 1'b0);
        queue_char(CHR_9, 1'b0);
        queue_char(CHR_STAR, 1'b0);
        queue_char(CHR_HASH, 1'b0);
        queue_char(CHR_LA, 1'b0);
        queue_char(CHR_LC, 1'b0);
        queue_char(CHR_UA, 1'b0);
        queue_char(CHR_UC, 1'b0);
        queue_char(CHR_PLUS, 1'b0);
        queue_char(CHR_UA + 8'd1, 1'b1);
        // lone plus as last: empty string
        queue_char(CHR_PLUS, 1'b1);
        // plus ends an even string, then one with a held digit
        queue_char(CHR_0 + 8'd1, 1'b0);
        queue_char(CHR_LA + 8'd1, 1'b0);
        queue_char(CHR_PLUS, 1'b1);
        queue_char(CHR_0 + 8'd7, 1'b0);
        queue_char(CHR_PLUS, 1'b1);
        // bad character mid-string drops the held digit, rest ignored up to tlast
        queue_char(CHR_0 + 8'd3, 1'b0);
        queue_char(CHR_0 - 8'd1, 1'b0);
        queue_char(CHR_9, 1'b0);
        queue_char(CHR_9 + 8'd1, 1'b1);
        // code extremes and range edges as bad characters
        queue_char(8'hFF, 1'b1);
        queue_char(8'h00, 1'b1);
        queue_char(CHR_LC + 8'd1, 1'b1);
        queue_char(CHR_UA - 8'd1, 1'b0);
        queue_char(CHR_UC + 8'd1, 1'b1);

        // Long strings around the digit limit: full length (128 bytes),
        // one over on the last character, and one over with more to ignore.
        queue_string(DIGIT_LIMIT, 3);
        queue_string(DIGIT_LIMIT + 1, 3);
        queue_string(DIGIT_LIMIT + 3, 3);
        queue_string($urandom_range(DIGIT_LIMIT - 4, DIGIT_LIMIT + 4), 0);

        // Mostly short well-formed strings, some broken, some noise
        while (char_q.size() < ITEM_TARGET) begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 80)
                queue_string($urandom_range(1, 16), 0);
            else if (pick < 92)
                queue_string($urandom_range(1, 12), 1);
            else
                queue_string($urandom_range(1, 6), 2);
        end

        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (char_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (bcd_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d characters in %0d strings; checked %0d results",
                 chars_sent, strings_sent, results_seen);
        $display("  %0d packed bytes, %0d invalid-char ends, %0d overflow ends, %0d mismatches",
                 bytes_seen, invalid_seen, overflow_seen, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/dsbcd_pkg.sv
sv/dsbcd_map.sv
sv/dsbcd_pack.sv
sv/dial_string_to_packed_bcd.sv
bench/dial_string_to_packed_bcd_tb.sv
